>>> hw/rtl/stc_pkg.sv
// Package for the tristimulus integrator: constants, mode codes and shared types.
`default_nettype none
package stc_pkg;

  localparam int NUM_WL   = 401;
  localparam int IDX_W    = 9;
  localparam int CMF_W    = 16;
  localparam int ACC_W    = 58;
  localparam int SUM_W    = 42;
  localparam int TRI_W    = 24;
  localparam int CHR_W    = 16;
  localparam int NUM_W    = 81;
  localparam int DEN_W    = 58;
  localparam int Q_W      = 32;
  localparam int S_W      = 29;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ILLUM = 2'd1,
    MODE_REFL  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic go;
    logic chroma;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TRI_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/stc_div.sv
// Restoring divider giving round-half-up of num/den, saturated to 24 or 16 bits.
`default_nettype none
module stc_div
  import stc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire div_req_t         req,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output div_rsp_t              rsp
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             run_r;
  logic             done_r;
  logic             chroma_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_nxt;
  logic             rnd;
  logic [Q_W:0]     q_rnd;
  logic [Q_W:0]     lim;
  logic [Q_W:0]     quot;

  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    qbit    = (rem_sh >= {1'b0, den_r});
    diff    = rem_sh - {1'b0, den_r};
    rem_nxt = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    // Round half up: the remainder is at least half the divisor.
    rnd     = ({rem_r, 1'b0} >= {1'b0, den_r});
    q_rnd   = {1'b0, q_r} + {{Q_W{1'b0}}, rnd};
    lim     = chroma_r ? (Q_W+1)'((1 << CHR_W) - 1) : (Q_W+1)'((1 << TRI_W) - 1);
    quot    = (ovf_r || (q_rnd > lim)) ? lim : q_rnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        num_r    <= num_i;
        den_r    <= den_i;
        rem_r    <= '0;
        q_r      <= '0;
        ovf_r    <= 1'b0;
        chroma_r <= req.chroma;
        cnt_r    <= CNT_W'(NUM_W - 1);
        run_r    <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[Q_W-2:0], qbit};
        ovf_r <= ovf_r | (qbit && (cnt_r >= CNT_W'(Q_W)));
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot[TRI_W-1:0];

endmodule
`default_nettype wire

>>> hw/rtl/spectrum_tristimulus_chromaticity.sv
// Channel  Handshake         Payload
// input    start / busy      in_mode, in_wl_index, in_spd_sample, in_reflectance,
//                            in_cmf_x, in_cmf_y, in_cmf_z, in_last
// result   out_valid strobe  out_status, out_tri_x/y/z, out_chroma_u/v/x/y
//
// A table load leaves busy low. A sample passes through table read, product and
// accumulate. A last sample adds up to seven passes through the 81-step serial
// divider plus the sequencing states. Reset clears the accumulators and the
// sequencer; the table memory holds no reset value. The receiver cannot stall:
// each result shows for one cycle.
`default_nettype none
module spectrum_tristimulus_chromaticity
  import stc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_mode,
  input  wire logic [IDX_W-1:0] in_wl_index,
  input  wire logic [15:0]      in_spd_sample,
  input  wire logic [15:0]      in_reflectance,
  input  wire logic [CMF_W-1:0] in_cmf_x,
  input  wire logic [CMF_W-1:0] in_cmf_y,
  input  wire logic [CMF_W-1:0] in_cmf_z,
  input  wire logic             in_last,
  output logic                  out_valid,
  output logic                  out_status,
  output logic [TRI_W-1:0]      out_tri_x,
  output logic [TRI_W-1:0]      out_tri_y,
  output logic [TRI_W-1:0]      out_tri_z,
  output logic [CHR_W-1:0]      out_chroma_u,
  output logic [CHR_W-1:0]      out_chroma_v,
  output logic [CHR_W-1:0]      out_chroma_x,
  output logic [CHR_W-1:0]      out_chroma_y
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_ACC  = 9'b000000100,
    S_PREP = 9'b000001000,
    S_NUM  = 9'b000010000,
    S_WAIT = 9'b000100000,
    S_SUM  = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t state_r;

  logic [3*CMF_W-1:0] mem [NUM_WL];
  logic [3*CMF_W-1:0] rd_r;

  logic             accept;
  logic             in_range;
  logic             illum_r;
  logic             last_r;
  logic             inr_r;
  logic [31:0]      w_r;
  logic [47:0]      px_r, py_r, pz_r;
  logic [ACC_W-1:0] acc_x_r, acc_y_r, acc_z_r;
  logic [SUM_W-1:0] illum_sum_r;
  logic [DEN_W-1:0] den_tri_r;
  logic [2:0]       k_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic             go_r;
  logic             chroma_r;
  logic             status_r;
  logic [TRI_W-1:0] tx_r, ty_r, tz_r;
  logic [CHR_W-1:0] u_r, v_r, x_r, y_r;
  logic [S_W-1:0]   s1_r, s2_r;

  logic [ACC_W-1:0] a_sel;
  logic [ACC_W+4:0] a25;
  logic [NUM_W-1:0] num_tri;
  logic [NUM_W-1:0] num_chr;
  logic [DEN_W-1:0] den_chr;
  logic [TRI_W+18:0] ty6;
  div_req_t         req;
  div_rsp_t         rsp;

  assign accept   = start && !busy;
  assign in_range = (in_wl_index < IDX_W'(NUM_WL));
  assign busy     = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (accept && in_range && (in_mode == MODE_LOAD)) begin
      mem[in_wl_index] <= {in_cmf_x, in_cmf_y, in_cmf_z};
    end
    if (accept && in_range) begin
      rd_r <= mem[in_wl_index];
    end
  end

  always_comb begin
    case (k_r)
      3'd0:    a_sel = acc_x_r;
      3'd1:    a_sel = acc_y_r;
      default: a_sel = acc_z_r;
    endcase
    // Multiply by 25; the powers of two of the scale follow as shifts.
    a25     = {1'b0, a_sel, 4'b0} + {2'b0, a_sel, 3'b0} + {5'b0, a_sel};
    num_tri = illum_r ? {a25, 18'b0} : {15'b0, a25, 3'b0};
    ty6     = {1'b0, ty_r, 18'b0} + {2'b0, ty_r, 17'b0};
    case (k_r)
      3'd3:    num_chr = {39'b0, tx_r, 18'b0};
      3'd4:    num_chr = {38'b0, ty6};
      3'd5:    num_chr = {41'b0, tx_r, 16'b0};
      default: num_chr = {41'b0, ty_r, 16'b0};
    endcase
    den_chr = (k_r == 3'd3 || k_r == 3'd4) ? {{(DEN_W-S_W){1'b0}}, s1_r}
                                           : {{(DEN_W-S_W){1'b0}}, s2_r};
  end

  assign req.go     = go_r;
  assign req.chroma = chroma_r;

  stc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .num_i (num_r),
    .den_i (den_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_z_r     <= '0;
      illum_sum_r <= '0;
      go_r        <= 1'b0;
      k_r         <= '0;
    end else begin
      go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_mode == MODE_ILLUM || in_mode == MODE_REFL)) begin
            illum_r <= (in_mode == MODE_ILLUM);
            last_r  <= in_last;
            inr_r   <= in_range;
            w_r     <= {16'b0, in_spd_sample} *
                       {16'b0, ((in_mode == MODE_ILLUM) ? 16'h8000 : in_reflectance)};
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          px_r    <= w_r * rd_r[3*CMF_W-1:2*CMF_W];
          py_r    <= w_r * rd_r[2*CMF_W-1:CMF_W];
          pz_r    <= w_r * rd_r[CMF_W-1:0];
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (inr_r) begin
            acc_x_r <= acc_x_r + {10'b0, px_r};
            acc_y_r <= acc_y_r + {10'b0, py_r};
            acc_z_r <= acc_z_r + {10'b0, pz_r};
          end
          state_r <= last_r ? S_PREP : S_IDLE;
        end
        S_PREP: begin
          status_r <= 1'b0;
          tx_r <= '0; ty_r <= '0; tz_r <= '0;
          u_r  <= '0; v_r  <= '0; x_r  <= '0; y_r <= '0;
          k_r  <= '0;
          if (illum_r) begin
            illum_sum_r <= acc_y_r[ACC_W-1] ? '1 : acc_y_r[ACC_W-2:15];
            den_tri_r   <= acc_y_r;
            if (acc_y_r == '0) begin
              status_r <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_NUM;
            end
          end else begin
            den_tri_r <= {{(DEN_W-SUM_W){1'b0}}, illum_sum_r};
            if (illum_sum_r == '0) begin
              status_r <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_NUM;
            end
          end
        end
        S_NUM: begin
          if (k_r <= 3'd2) begin
            num_r    <= num_tri;
            den_r    <= den_tri_r;
            chroma_r <= 1'b0;
            go_r     <= 1'b1;
            state_r  <= S_WAIT;
          end else if (den_chr == '0) begin
            // Zero denominator: the chromaticity stays at zero.
            k_r <= k_r + 3'd1;
            if (k_r == 3'd6) state_r <= S_OUT;
          end else begin
            num_r    <= num_chr;
            den_r    <= den_chr;
            chroma_r <= 1'b1;
            go_r     <= 1'b1;
            state_r  <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            case (k_r)
              3'd0:    tx_r <= rsp.quot;
              3'd1:    ty_r <= rsp.quot;
              3'd2:    tz_r <= rsp.quot;
              3'd3:    u_r  <= rsp.quot[CHR_W-1:0];
              3'd4:    v_r  <= rsp.quot[CHR_W-1:0];
              3'd5:    x_r  <= rsp.quot[CHR_W-1:0];
              default: y_r  <= rsp.quot[CHR_W-1:0];
            endcase
            k_r <= k_r + 3'd1;
            if (k_r == 3'd2)      state_r <= S_SUM;
            else if (k_r == 3'd6) state_r <= S_OUT;
            else                  state_r <= S_NUM;
          end
        end
        S_SUM: begin
          s1_r <= {5'b0, tx_r} + ({1'b0, ty_r, 4'b0} - {5'b0, ty_r})
                + ({4'b0, tz_r, 1'b0} + {5'b0, tz_r});
          s2_r <= {5'b0, tx_r} + {5'b0, ty_r} + {5'b0, tz_r};
          state_r <= S_NUM;
        end
        S_OUT: begin
          acc_x_r <= '0;
          acc_y_r <= '0;
          acc_z_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = (state_r == S_OUT);
  assign out_status   = status_r;
  assign out_tri_x    = tx_r;
  assign out_tri_y    = ty_r;
  assign out_tri_z    = tz_r;
  assign out_chroma_u = u_r;
  assign out_chroma_v = v_r;
  assign out_chroma_x = x_r;
  assign out_chroma_y = y_r;

endmodule
`default_nettype wire

>>> hw/rtl/stc_chk.sv
// Port-level checker for the tristimulus integrator, bound to the top level.
`default_nettype none
module stc_chk
  import stc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       in_mode,
  input wire logic             out_valid,
  input wire logic             out_status,
  input wire logic [TRI_W-1:0] out_tri_x,
  input wire logic [TRI_W-1:0] out_tri_y,
  input wire logic [CHR_W-1:0] out_chroma_u,
  input wire logic [CHR_W-1:0] out_chroma_x
);

  // A result ends the work of an item, so busy is still up when it shows.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held for more than one cycle");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_tri_x == '0 && out_tri_y == '0 &&
      out_chroma_u == '0 && out_chroma_x == '0))
    else $error("zero-luminance result is not zero");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_LOAD) |=> !busy)
    else $error("table load held the block busy");

endmodule

bind spectrum_tristimulus_chromaticity stc_chk u_stc_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_mode      (in_mode),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_tri_x    (out_tri_x),
  .out_tri_y    (out_tri_y),
  .out_chroma_u (out_chroma_u),
  .out_chroma_x (out_chroma_x)
);
`default_nettype wire
